>>> src/fec_pkg.sv
package fec_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 15;
    localparam int CNT_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_W     = 14;
    localparam int MAX_DELAY  = 2 ** ADDR_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [LIMIT_W-1:0]         limit_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    localparam cfg_idx_t REG_GAIN  = 2'd0;
    localparam cfg_idx_t REG_DELAY = 2'd1;
    localparam cfg_idx_t REG_LIMIT = 2'd2;

    localparam gain_t  GAIN_RESET  = 16'd8192;
    localparam addr_t  DELAY_RESET = '0;
    localparam limit_t LIMIT_RESET = 15'd32767;
    localparam cnt_t   CNT_MAX     = '1;

endpackage

>>> src/feedback_echo_comb.sv
// channel   | ports                                 | beat
// ----------+---------------------------------------+------------------------------------
// config    | cfg_we, cfg_index, cfg_wdata          | write when cfg_we high, no wait
// input     | s_valid, s_ready, s_sample, s_last    | one sample per beat
// output    | m_valid, m_ready, m_out_sample,       | one echoed sample per input beat
//           | m_out_last                            |
//
// one sample per cycle sustained unless the output stalls; a result is offered after its
// beat: ring read on the beat edge, then compute and ring write into the output register
// a delay of one sample is served by forwarding the last written output past the ring
// synchronous active-low reset clears pointer, counter, registers and valids; the ring
// needs no clearing since the sample counter keeps reads behind writes
// a stalled output holds the compute stage, which in turn holds s_ready low
module feedback_echo_comb (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  fec_pkg::cfg_idx_t   cfg_index,
    input  fec_pkg::cfg_data_t  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  fec_pkg::sample_t    s_sample,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output fec_pkg::sample_t    m_out_sample,
    output logic                m_out_last
);
    import fec_pkg::*;

    gain_t   gain_reg;
    addr_t   delay_reg;
    limit_t  limit_reg;

    addr_t   wp_reg;
    cnt_t    seen_reg;
    cnt_t    seen_next;

    logic    b_valid_reg;
    logic    b_valid_next;
    sample_t b_sample_reg;
    logic    b_last_reg;
    logic    b_early_reg;
    logic    b_dzero_reg;
    logic    b_fwd_reg;
    addr_t   b_wp_reg;
    sample_t rd_data_reg;
    sample_t y_prev_reg;

    logic    o_valid_reg;
    logic    o_valid_next;
    sample_t o_sample_reg;
    logic    o_last_reg;

    logic [SAMPLE_W-1:0] ring_mem [MAX_DELAY];

    logic    b_adv;
    logic    s_acc;
    addr_t   rd_addr;
    logic    fwd_next;

    sample_t                   delayed;
    logic [SAMPLE_W:0]         mag;
    logic [SAMPLE_W+GAIN_W:0]  prod;
    logic [SAMPLE_W+2:0]       scaled;
    logic [SAMPLE_W:0]         neg_mag;
    logic signed [SAMPLE_W:0]  echo;
    logic signed [SAMPLE_W+1:0] sum;
    logic signed [SAMPLE_W+1:0] lim_pos;
    logic signed [SAMPLE_W+1:0] lim_neg;
    sample_t                   y_clamp;
    sample_t                   y;

    assign b_adv   = b_valid_reg && (!o_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || b_adv;
    assign s_acc   = s_valid && s_ready;
    assign rd_addr = wp_reg - delay_reg;
    assign fwd_next = b_adv && (b_wp_reg == rd_addr);

    assign m_valid      = o_valid_reg;
    assign m_out_sample = o_sample_reg;
    assign m_out_last   = o_last_reg;

    // echo term: magnitude product, truncate toward zero, clamp to 16 bits; add input, clamp to limit
    always_comb begin
        if (b_dzero_reg) begin
            delayed = b_sample_reg;
        end else if (b_fwd_reg) begin
            delayed = y_prev_reg;
        end else begin
            delayed = rd_data_reg;
        end

        if (delayed[SAMPLE_W-1]) begin
            mag = (SAMPLE_W+1)'(0) - {1'b1, delayed};
        end else begin
            mag = {1'b0, delayed};
        end

        prod   = (SAMPLE_W+GAIN_W+1)'(mag) * (SAMPLE_W+GAIN_W+1)'(gain_reg);
        scaled = prod[SAMPLE_W+GAIN_W:FRAC_W];

        if (delayed[SAMPLE_W-1]) begin
            neg_mag = (scaled > (SAMPLE_W+3)'(32768)) ? (SAMPLE_W+1)'(32768)
                                                      : scaled[SAMPLE_W:0];
            echo = $signed((SAMPLE_W+1)'(0) - neg_mag);
        end else begin
            neg_mag = '0;
            echo = (scaled > (SAMPLE_W+3)'(32767)) ? $signed((SAMPLE_W+1)'(32767))
                                                   : $signed({1'b0, scaled[SAMPLE_W-1:0]});
        end

        sum     = $signed({{2{b_sample_reg[SAMPLE_W-1]}}, b_sample_reg})
                + $signed({echo[SAMPLE_W], echo});
        lim_pos = $signed({3'b000, limit_reg});
        lim_neg = -lim_pos;

        if (sum > lim_pos) begin
            y_clamp = sample_t'(lim_pos);
        end else if (sum < lim_neg) begin
            y_clamp = sample_t'(lim_neg);
        end else begin
            y_clamp = sample_t'(sum);
        end

        y = b_early_reg ? b_sample_reg : y_clamp;
    end

    always_comb begin
        if (s_last) begin
            seen_next = '0;
        end else if (seen_reg == CNT_MAX) begin
            seen_next = seen_reg;
        end else begin
            seen_next = seen_reg + cnt_t'(1);
        end

        if (s_acc) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end

        if (b_adv) begin
            o_valid_next = 1'b1;
        end else if (m_ready) begin
            o_valid_next = 1'b0;
        end else begin
            o_valid_next = o_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            delay_reg   <= DELAY_RESET;
            limit_reg   <= LIMIT_RESET;
            wp_reg      <= '0;
            seen_reg    <= '0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN:  gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_DELAY: delay_reg <= cfg_wdata[ADDR_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                wp_reg   <= wp_reg + addr_t'(1);
                seen_reg <= seen_next;
            end
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_sample_reg <= s_sample;
            b_last_reg   <= s_last;
            b_early_reg  <= {1'b0, seen_reg} < {2'b00, delay_reg};
            b_dzero_reg  <= (delay_reg == '0);
            b_fwd_reg    <= fwd_next;
            b_wp_reg     <= wp_reg;
        end
        if (b_adv) begin
            y_prev_reg   <= y;
            o_sample_reg <= y;
            o_last_reg   <= b_last_reg;
        end
    end

    // history ring
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (b_adv) begin
            ring_mem[b_wp_reg] <= y;
        end
    end

    a_wp_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_wp_reg + addr_t'(1)) == wp_reg)
        else $error("compute stage pointer out of step with write pointer");

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> wp_reg == $past(wp_reg) + addr_t'(1))
        else $error("write pointer did not advance on input beat");

    a_clip_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_last) |=> seen_reg == '0)
        else $error("sample counter not cleared at end of clip");

    a_fwd_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && fwd_next) |-> delay_reg == addr_t'(1))
        else $error("forwarding taken with delay other than one");

    a_out_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_early_reg) |->
            ($signed({{2{y[SAMPLE_W-1]}}, y}) <= lim_pos &&
             $signed({{2{y[SAMPLE_W-1]}}, y}) >= lim_neg))
        else $error("echoed sample outside limit");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> b_valid_reg)
        else $error("compute stage dropped a stalled sample");

endmodule
